// ===== design/ftm_pkg.sv =====
// Shared types, codes and helpers for the fault table manager.
`default_nettype none
package ftm_pkg;

   localparam int TABLE_SIZE_DEF = 32;
   localparam int ID_WIDTH_DEF   = 16;

   localparam int OCC_W = 16;
   localparam int SEV_W = 2;

   localparam logic [OCC_W-1:0] OCC_MAX = 16'hFFFF;

   // commands
   localparam logic [1:0] CMD_REPORT    = 2'd0;
   localparam logic [1:0] CMD_CLEAR     = 2'd1;
   localparam logic [1:0] CMD_QUERY     = 2'd2;
   localparam logic [1:0] CMD_CLEAR_ALL = 2'd3;

   // result status
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_FULL      = 2'd1;
   localparam logic [1:0] STS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STS_LATCHED   = 2'd3;

   localparam logic [SEV_W-1:0] SEV_CRITICAL = 2'd3;

   // result word, first field in the highest bits
   typedef struct packed {
      logic             pad;
      logic [1:0]       worst_status;
      logic [5:0]       active_count;
      logic [OCC_W-1:0] record_occurrences;
      logic             record_latched;
      logic [SEV_W-1:0] record_severity;
      logic             record_valid;
      logic             fault_active;
      logic [1:0]       status_code;
   } rsp_word_type;

   // scan unit status toward the sequencer
   typedef struct packed {
      logic             done;
      logic             found;
      logic             free_found;
      logic             m_latched;
      logic [SEV_W-1:0] m_sev;
      logic [OCC_W-1:0] m_occ;
      logic [SEV_W-1:0] worst;
   } scan_stat_type;

   function automatic logic [SEV_W-1:0] sev_max(input logic [SEV_W-1:0] a,
                                                input logic [SEV_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage
`default_nettype wire

// ===== design/fault_table_manager_unit.sv =====
// Fault table manager top level: command sequencer, live bits, entry RAM and result register.
//
// Input channel req_*: one command word per handshake (tuser = command, tdata = id and
// severity). Output channel rsp_*: exactly one result word per command, in order.
// Entries (id, severity, occurrence count, latched flag) sit in one RAM with a
// registered read; a live bit per entry sits in flip-flops.
// Report, clear and query read the whole table once through the RAM read port, one
// entry a cycle; clear-all skips the scan and goes straight to the result step.
// One command is in work at a time; req_tready is high only while idle.
// The result sits in an output register: the next command is taken while it waits.
// If rsp_tready stays low, a second finished command holds in its write-back step
// until the result register empties; nothing is dropped.
// Reset clears all live bits, the live count and both handshakes; RAM contents need
// no clearing since a dead entry is never looked at. Clear-all works the same way.
`default_nettype none
module fault_table_manager_unit import ftm_pkg::*; #(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF,
   parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // fault_id[15:0], severity[17:16], zero pad
   input  wire logic [1:0]  req_tuser,  // cmd[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status_code[1:0], fault_active[2], record_valid[3], record_severity[5:4],
   // record_latched[6], record_occurrences[22:7], active_count[28:23],
   // worst_status[30:29], zero pad
   output logic      [31:0] rsp_tdata
);

   localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int LW = $clog2(TABLE_SIZE + 1);
   localparam int WW = ID_WIDTH + OCC_W + SEV_W + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [1:0]            cmd_ff, cmd_in;
   logic [ID_WIDTH-1:0]   id_ff, id_in;
   logic [SEV_W-1:0]      sev_ff, sev_in;
   logic [TABLE_SIZE-1:0] live_ff, live_in;
   logic [LW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_data_ff, rsp_data_in;

   logic          accept, out_free, scan_start;
   scan_stat_type stat;
   logic [AW-1:0] match_addr, free_addr;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [WW-1:0] rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [WW-1:0] wr_data;

   logic [OCC_W-1:0] n_occ;
   logic [SEV_W-1:0] n_sev;
   logic             n_lat;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign scan_start = accept && (req_tuser != CMD_CLEAR_ALL);

   ftm_scan #(
      .TABLE_SIZE (TABLE_SIZE),
      .ID_WIDTH   (ID_WIDTH)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .id         (id_ff),
      .live       (live_ff),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .stat       (stat),
      .match_addr (match_addr),
      .free_addr  (free_addr)
   );

   ftm_ram #(
      .WIDTH (WW),
      .DEPTH (TABLE_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // report update of the matched entry, or fresh entry in the free slot
   always_comb begin
      if (stat.found) begin
         n_occ = (stat.m_occ == OCC_MAX) ? stat.m_occ : stat.m_occ + OCC_W'(1);
         n_sev = sev_max(stat.m_sev, sev_ff);
         n_lat = stat.m_latched || (n_sev == SEV_CRITICAL);
      end else begin
         n_occ = OCC_W'(1);
         n_sev = sev_ff;
         n_lat = (sev_ff == SEV_CRITICAL);
      end
   end

   assign wr_addr = stat.found ? match_addr : free_addr;
   assign wr_data = {n_lat, n_sev, n_occ, id_ff};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      sev_in       = sev_ff;
      live_in      = live_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_tuser;
               id_in    = ID_WIDTH'(req_tdata[15:0]);
               sev_in   = req_tdata[17:16];
               state_in = (req_tuser == CMD_CLEAR_ALL) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.worst_status = stat.worst;
               unique case (cmd_ff)
                  CMD_REPORT: begin
                     if (stat.found || stat.free_found) begin
                        wr_en = 1'b1;
                        if (!stat.found) begin
                           live_in[free_addr] = 1'b1;
                           count_in = count_ff + LW'(1);
                        end
                        rsp_data_in.record_valid       = 1'b1;
                        rsp_data_in.record_severity    = n_sev;
                        rsp_data_in.record_latched     = n_lat;
                        rsp_data_in.record_occurrences = n_occ;
                        rsp_data_in.worst_status       = sev_max(stat.worst, n_sev);
                     end else begin
                        rsp_data_in.status_code = STS_FULL;
                     end
                  end
                  CMD_CLEAR: begin
                     if (!stat.found) begin
                        rsp_data_in.status_code = STS_NOT_FOUND;
                     end else if (stat.m_latched) begin
                        rsp_data_in.status_code  = STS_LATCHED;
                        rsp_data_in.worst_status = sev_max(stat.worst, stat.m_sev);
                     end else begin
                        live_in[match_addr] = 1'b0;
                        if (count_ff != '0) begin
                           count_in = count_ff - LW'(1);
                        end
                     end
                  end
                  CMD_QUERY: begin
                     rsp_data_in.fault_active = stat.found;
                     if (stat.found) begin
                        rsp_data_in.worst_status = sev_max(stat.worst, stat.m_sev);
                     end
                  end
                  CMD_CLEAR_ALL: begin
                     live_in  = '0;
                     count_in = '0;
                     rsp_data_in.worst_status = '0;
                  end
                  default: begin
                  end
               endcase
               rsp_data_in.active_count = 6'(count_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      sev_ff      <= sev_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== design/ftm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ftm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== design/ftm_scan.sv =====
// Table scan: walks every entry once, finds the id match, first free slot and worst severity of the other live entries.
`default_nettype none
module ftm_scan import ftm_pkg::*; #(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF,
   parameter int ID_WIDTH   = ID_WIDTH_DEF,
   localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1,
   localparam int WW = ID_WIDTH + OCC_W + SEV_W + 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [ID_WIDTH-1:0]   id,
   input  wire logic [TABLE_SIZE-1:0] live,
   output logic                       rd_en,
   output logic      [AW-1:0]         rd_addr,
   input  wire logic [WW-1:0]         rd_data,
   output scan_stat_type              stat,
   output logic      [AW-1:0]         match_addr,
   output logic      [AW-1:0]         free_addr
);

   localparam int CW = $clog2(TABLE_SIZE + 1);

   logic             busy_ff, busy_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             chk_valid_ff, chk_valid_in;
   logic [AW-1:0]    chk_addr_ff, chk_addr_in;
   logic             found_ff, found_in;
   logic             free_ff, free_in;
   logic             m_lat_ff, m_lat_in;
   logic [SEV_W-1:0] m_sev_ff, m_sev_in;
   logic [OCC_W-1:0] m_occ_ff, m_occ_in;
   logic [AW-1:0]    m_addr_ff, m_addr_in;
   logic [AW-1:0]    f_addr_ff, f_addr_in;
   logic [SEV_W-1:0] worst_ff, worst_in;

   logic                live_chk, hit, free_hit, issue, done;
   logic [ID_WIDTH-1:0] e_id;
   logic [OCC_W-1:0]    e_occ;
   logic [SEV_W-1:0]    e_sev;
   logic                e_lat;

   assign e_id  = rd_data[ID_WIDTH-1:0];
   assign e_occ = rd_data[ID_WIDTH+OCC_W-1:ID_WIDTH];
   assign e_sev = rd_data[ID_WIDTH+OCC_W+SEV_W-1:ID_WIDTH+OCC_W];
   assign e_lat = rd_data[WW-1];

   assign issue    = busy_ff && (cnt_ff < CW'(TABLE_SIZE));
   assign done     = busy_ff && !issue && !chk_valid_ff;
   assign live_chk = live[chk_addr_ff];
   assign hit      = chk_valid_ff && live_chk && (e_id == id) && !found_ff;
   assign free_hit = chk_valid_ff && !live_chk && !free_ff;

   assign rd_en   = issue;
   assign rd_addr = cnt_ff[AW-1:0];

   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      chk_valid_in = issue;
      chk_addr_in  = cnt_ff[AW-1:0];
      found_in     = found_ff;
      free_in      = free_ff;
      m_lat_in     = m_lat_ff;
      m_sev_in     = m_sev_ff;
      m_occ_in     = m_occ_ff;
      m_addr_in    = m_addr_ff;
      f_addr_in    = f_addr_ff;
      worst_in     = worst_ff;
      if (start) begin
         busy_in      = 1'b1;
         cnt_in       = '0;
         chk_valid_in = 1'b0;
         found_in     = 1'b0;
         free_in      = 1'b0;
         worst_in     = '0;
      end else begin
         if (issue) begin
            cnt_in = cnt_ff + CW'(1);
         end
         if (done) begin
            busy_in = 1'b0;
         end
         if (hit) begin
            found_in  = 1'b1;
            m_lat_in  = e_lat;
            m_sev_in  = e_sev;
            m_occ_in  = e_occ;
            m_addr_in = chk_addr_ff;
         end
         if (free_hit) begin
            free_in   = 1'b1;
            f_addr_in = chk_addr_ff;
         end
         // matched entry is left out here; the sequencer adds its severity (updated on a report) where it stays live
         if (chk_valid_ff && live_chk && !hit) begin
            worst_in = sev_max(worst_ff, e_sev);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         chk_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         worst_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         chk_valid_ff <= chk_valid_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         worst_ff     <= worst_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_addr_ff <= chk_addr_in;
      m_lat_ff    <= m_lat_in;
      m_sev_ff    <= m_sev_in;
      m_occ_ff    <= m_occ_in;
      m_addr_ff   <= m_addr_in;
      f_addr_ff   <= f_addr_in;
   end

   assign stat.done       = done;
   assign stat.found      = found_ff;
   assign stat.free_found = free_ff;
   assign stat.m_latched  = m_lat_ff;
   assign stat.m_sev      = m_sev_ff;
   assign stat.m_occ      = m_occ_ff;
   assign stat.worst      = worst_ff;
   assign match_addr      = m_addr_ff;
   assign free_addr       = f_addr_ff;

endmodule
`default_nettype wire

// ===== design/ftm_checker.sv =====
// Port-level checks for the fault table manager, bound to the top level.
`default_nettype none
module ftm_checker #(
   parameter int TABLE_SIZE = 32
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // a held result word must not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // one command in work: the input closes right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command accepted during work");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[28:23] <= 6'(TABLE_SIZE))
      else $error("active count beyond table size");

   a_empty_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[28:23] == 6'd0 && TABLE_SIZE < 64 |-> rsp_tdata[30:29] == 2'd0)
      else $error("worst status set with empty table");

   a_record_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |->
         rsp_tdata[1:0] == 2'd0 && rsp_tdata[22:7] != 16'd0 && !rsp_tdata[2])
      else $error("record flagged valid on a failed or non-report command");

endmodule

bind fault_table_manager_unit ftm_checker #(.TABLE_SIZE(TABLE_SIZE)) u_ftm_checker (.*);
`default_nettype wire
